// ----- rtl/core/cfdp_pkg.sv -----
// Shared constants, types and register indexes for the command frame parser.
// No dependencies; imported by every module in rtl/core.
package cfdp_pkg;

    localparam int FRAME_LIMIT  = 49;
    localparam int VALUE_FIELDS = 5;
    localparam int OUT_VALUES   = 5;

    localparam int LEN_W   = $clog2(FRAME_LIMIT + 1);
    localparam int FIELD_W = $clog2(VALUE_FIELDS + 2);
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] START_RESET = 8'd83;
    localparam logic [7:0] END_RESET   = 8'd90;
    localparam logic [7:0] SEP_RESET   = 8'd44;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [35:0] POS_LIMIT = 36'd2147483647;
    localparam logic [35:0] NEG_LIMIT = 36'd2147483648;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP   = 2'd2;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [VALUE_FIELDS-1:0][31:0] vals_t;

    typedef struct packed {
        logic [7:0] start_char;
        logic [7:0] end_char;
        logic [7:0] sep_char;
    } cfg_t;

    typedef struct packed {
        logic [3:0]                  msg_type;
        logic [OUT_VALUES-1:0][31:0] values;
    } result_t;

endpackage

// ----- rtl/core/cfdp_in_reg.sv -----
// Input register holding one received byte until the parser takes it.
// Depends on cfdp_pkg.
module cfdp_in_reg
    import cfdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       q_valid,
    output logic [7:0] q_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign q_valid = valid_reg;
    assign q_byte  = byte_reg;

endmodule

// ----- rtl/core/cfdp_core.sv -----
// Frame state and per-byte field parsing; one byte per cycle while advance is high.
// Depends on cfdp_pkg; feeds cfdp_out_reg.
module cfdp_core
    import cfdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output logic       emit,
    output result_t    res
);

    len_t       len_reg,   len_next;
    logic [3:0] type_reg,  type_next;
    field_t     fnum_reg,  fnum_next;
    phase_t     phase_reg, phase_next;
    logic       neg_reg,   neg_next;
    logic [31:0] acc_reg,  acc_next;
    vals_t      vals_reg,  vals_next;

    logic        is_digit;
    logic        is_space;
    logic [3:0]  digit;
    logic [35:0] prod;
    logic [35:0] limit;
    logic [31:0] acc_digit;
    logic        take;

    function automatic vals_t commit(vals_t v, field_t f, logic n, logic [31:0] a);
        vals_t r;
        r = v;
        for (int i = 0; i < VALUE_FIELDS; i++)
        begin
            if (f == FIELD_W'(i + 1))
            begin
                r[i] = n ? (32'd0 - a) : a;
            end
        end
        return r;
    endfunction

    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_space = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
    assign digit    = 4'(rx_byte - CH_ZERO);

    // saturate when acc*10 + d would exceed the limit for this sign
    always_comb
    begin
        limit     = neg_reg ? NEG_LIMIT : POS_LIMIT;
        prod      = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {32'd0, digit};
        acc_digit = (prod > limit) ? limit[31:0] : prod[31:0];
    end

    always_comb
    begin
        len_next   = len_reg;
        type_next  = type_reg;
        fnum_next  = fnum_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        vals_next  = vals_reg;
        take       = 1'b0;
        emit       = 1'b0;

        if (len_reg == '0)
        begin
            if (rx_byte == cfg.start_char)
            begin
                take       = 1'b1;
                len_next   = len_t'(1);
                fnum_next  = '0;
                phase_next = PH_SKIP;
                neg_next   = 1'b0;
                acc_next   = '0;
                vals_next  = '0;
            end
        end
        else
        begin
            take = 1'b1;
            if ((len_reg == len_t'(1)) && (rx_byte != cfg.start_char))
            begin
                type_next = is_digit ? digit : 4'd0;
            end
            len_next = len_reg + len_t'(1);
            if (rx_byte == cfg.sep_char)
            begin
                vals_next = commit(vals_reg, fnum_reg, neg_reg, acc_reg);
                if (fnum_reg <= field_t'(VALUE_FIELDS))
                begin
                    fnum_next = fnum_reg + field_t'(1);
                end
                phase_next = PH_SKIP;
                neg_next   = 1'b0;
                acc_next   = '0;
            end
            else if ((fnum_reg >= field_t'(1)) && (fnum_reg <= field_t'(VALUE_FIELDS)))
            begin
                unique case (phase_reg)
                    PH_SKIP:
                    begin
                        if (is_space)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS))
                        begin
                            neg_next   = (rx_byte == CH_MINUS);
                            phase_next = PH_DIGITS;
                        end
                        else if (is_digit)
                        begin
                            phase_next = PH_DIGITS;
                            acc_next   = acc_digit;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            acc_next = acc_digit;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        if (take && (rx_byte == cfg.end_char))
        begin
            emit       = 1'b1;
            vals_next  = commit(vals_next, fnum_next, neg_next, acc_next);
            len_next   = '0;
            fnum_next  = '0;
            phase_next = PH_SKIP;
            neg_next   = 1'b0;
            acc_next   = '0;
        end
        else if (take && (len_next >= len_t'(FRAME_LIMIT)))
        begin
            len_next   = '0;
            fnum_next  = '0;
            phase_next = PH_SKIP;
            neg_next   = 1'b0;
            acc_next   = '0;
        end
    end

    always_comb
    begin
        res.msg_type = type_next;
        res.values   = '0;
        for (int i = 0; i < OUT_VALUES; i++)
        begin
            if (i < VALUE_FIELDS)
            begin
                res.values[i] = vals_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            type_reg  <= '0;
            fnum_reg  <= '0;
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            vals_reg  <= '0;
        end
        else if (advance)
        begin
            len_reg   <= len_next;
            type_reg  <= type_next;
            fnum_reg  <= fnum_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            vals_reg  <= vals_next;
        end
    end

    a_len_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg < len_t'(FRAME_LIMIT))
        else $error("frame length reached limit without drop");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg == '0) |-> ((fnum_reg == '0) && (phase_reg == PH_SKIP) && (acc_reg == '0)))
        else $error("number state not cleared while idle");

    a_skip_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> ((acc_reg == '0) && !neg_reg))
        else $error("accumulator or sign set while skipping spaces");

    a_acc_sat: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg <= NEG_LIMIT[31:0])
        else $error("accumulator beyond saturation limit");

    a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (len_reg != '0) && (len_next != '0)) |=>
        (len_reg == $past(len_reg) + len_t'(1)))
        else $error("frame length did not step by one");

endmodule

// ----- rtl/core/cfdp_out_reg.sv -----
// Result register: action flag decode and the output handshake.
// Depends on cfdp_pkg; takes results from cfdp_core.
module cfdp_out_reg
    import cfdp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  result_t            res,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         msg_type,
    output logic signed [31:0] value_a,
    output logic signed [31:0] value_b,
    output logic signed [31:0] value_c,
    output logic signed [31:0] value_d,
    output logic signed [31:0] value_e,
    output logic               recognized,
    output logic               send_ack,
    output logic               clear_target,
    output logic               link_alive
);

    logic    valid_reg, valid_next;
    result_t res_reg;
    logic    recog_reg, ack_reg, clear_reg, alive_reg;
    logic    recog_c, ack_c, clear_c, alive_c;

    always_comb
    begin
        recog_c = 1'b0;
        ack_c   = 1'b0;
        case (res.msg_type) inside
            4'd1, 4'd2, 4'd4, 4'd5, 4'd6:
            begin
                recog_c = 1'b1;
                ack_c   = 1'b1;
            end
            4'd3, 4'd8:
            begin
                recog_c = 1'b1;
            end
            default:
            begin
                recog_c = 1'b0;
            end
        endcase
        alive_c = (res.msg_type == 4'd8);
        clear_c = (res.msg_type == 4'd3) && (res.values[1] == 32'd3);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg   <= res;
            recog_reg <= recog_c;
            ack_reg   <= ack_c;
            clear_reg <= clear_c;
            alive_reg <= alive_c;
        end
    end

    assign out_valid    = valid_reg;
    assign msg_type     = res_reg.msg_type;
    assign value_a      = res_reg.values[0];
    assign value_b      = res_reg.values[1];
    assign value_c      = res_reg.values[2];
    assign value_d      = res_reg.values[3];
    assign value_e      = res_reg.values[4];
    assign recognized   = recog_reg;
    assign send_ack     = ack_reg;
    assign clear_target = clear_reg;
    assign link_alive   = alive_reg;

endmodule

// ----- rtl/core/command_frame_decimal_parser_unit.sv -----
// Top level of the command frame decimal parser: config registers and wiring.
// Depends on cfdp_pkg, cfdp_in_reg, cfdp_core, cfdp_out_reg.
//
//  channel  signals                          direction
//  in       in_valid/in_ready, rx_byte       byte stream in
//  out      out_valid/out_ready, msg_type,   one result per frame end
//           value_a..value_e, flags
//  cfg      cfg_valid/cfg_ready,             register writes, always ready
//           cfg_index, cfg_data
//
// One item per cycle sustained unless out_ready stalls; a byte is held in the input
// register, then parsed into the result register.
// The parse step is a single multiply-by-ten, add and saturate compare.
// A pending result that is not taken holds the input register; in_ready
// follows out_ready combinationally. Reset clears all frame state at once.
module command_frame_decimal_parser_unit
    import cfdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           msg_type,
    output logic signed [31:0]   value_a,
    output logic signed [31:0]   value_b,
    output logic signed [31:0]   value_c,
    output logic signed [31:0]   value_d,
    output logic signed [31:0]   value_e,
    output logic                 recognized,
    output logic                 send_ack,
    output logic                 clear_target,
    output logic                 link_alive,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cfg_t       cfg_reg;
    logic       q_valid;
    logic [7:0] q_byte;
    logic       advance;
    logic       emit;
    result_t    res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_char <= START_RESET;
            cfg_reg.end_char   <= END_RESET;
            cfg_reg.sep_char   <= SEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_START: cfg_reg.start_char <= cfg_data;
                CFG_END:   cfg_reg.end_char   <= cfg_data;
                CFG_SEP:   cfg_reg.sep_char   <= cfg_data;
                default:   cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign advance = q_valid && (!out_valid || out_ready);

    cfdp_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .advance  (advance),
        .q_valid  (q_valid),
        .q_byte   (q_byte)
    );

    cfdp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_byte (q_byte),
        .cfg     (cfg_reg),
        .emit    (emit),
        .res     (res)
    );

    cfdp_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && emit),
        .res          (res),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .msg_type     (msg_type),
        .value_a      (value_a),
        .value_b      (value_b),
        .value_c      (value_c),
        .value_d      (value_d),
        .value_e      (value_e),
        .recognized   (recognized),
        .send_ack     (send_ack),
        .clear_target (clear_target),
        .link_alive   (link_alive)
    );

endmodule
